### rtl/smm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_pkg
// Shared types, field widths and command codes of the square matrix multiplier.
// ----------------------------------------------------------------------------
package smm_pkg;

    // field widths of the words on the channels
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 4;
    localparam int VAL_W  = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 36;
    localparam int SIZE_W = 5;

    // a row emits at most this many columns
    localparam int ROW_LIMIT = 16;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // classified work handed from front to back
    typedef enum logic [1:0] {
        KIND_LOAD_A,
        KIND_LOAD_B,
        KIND_COMPUTE
    } smm_kind_t;

    typedef struct packed {
        smm_kind_t                kind;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [VAL_W-1:0]  value;
    } smm_item_t;

    // active dimension: zero acts as one, capped at the built dimension
    function automatic logic [SIZE_W-1:0] active_dim(input logic [SIZE_W-1:0] size,
                                                     input logic [SIZE_W-1:0] dim);
        logic [SIZE_W-1:0] n;
        n = size;
        if (n == '0)
        begin
            n = 5'd1;
        end
        if (n > dim)
        begin
            n = dim;
        end
        return n;
    endfunction

endpackage

### rtl/smm_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm channels
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface smm_req_if;
    logic                               valid;
    logic                               ready;
    logic [smm_pkg::CMD_W-1:0]          command;
    logic [smm_pkg::IDX_W-1:0]          row;
    logic [smm_pkg::IDX_W-1:0]          col;
    logic signed [smm_pkg::VAL_W-1:0]   value;

    modport source (output valid, command, row, col, value, input ready);
    modport sink   (input valid, command, row, col, value, output ready);
endinterface

interface smm_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [smm_pkg::ACC_W-1:0]   product;
    logic [smm_pkg::IDX_W-1:0]          out_row;
    logic [smm_pkg::IDX_W-1:0]          out_col;
    logic                               last;

    modport source (output valid, product, out_row, out_col, last, input ready);
    modport sink   (input valid, product, out_row, out_col, last, output ready);
endinterface

### rtl/smm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_front
// Accepts request words, drops those without effect and queues the rest.
// ----------------------------------------------------------------------------
module smm_front #(
    parameter int DIM = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    smm_req_if.sink                       request,
    input  logic [smm_pkg::SIZE_W-1:0]    n_dim,
    output smm_pkg::smm_item_t            q_item,
    output logic                          q_valid,
    input  logic                          q_pop
);

    localparam int QUEUE_DEPTH = 2;

    smm_pkg::smm_item_t q_mem_reg [QUEUE_DEPTH];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         cnt_reg;

    smm_pkg::smm_item_t item;
    logic               keep;
    logic               in_store;
    logic               push;
    logic               pop;

    // classify the incoming word
    assign in_store = ({1'b0, request.row} < smm_pkg::SIZE_W'(DIM)) &&
                      ({1'b0, request.col} < smm_pkg::SIZE_W'(DIM));

    always_comb
    begin
        item.row   = request.row;
        item.col   = request.col;
        item.value = request.value;
        item.kind  = smm_pkg::KIND_COMPUTE;
        keep       = 1'b0;
        case (request.command)
            smm_pkg::CMD_LOAD_A:
            begin
                item.kind = smm_pkg::KIND_LOAD_A;
                keep      = in_store;
            end
            smm_pkg::CMD_LOAD_B:
            begin
                item.kind = smm_pkg::KIND_LOAD_B;
                keep      = in_store;
            end
            smm_pkg::CMD_COMPUTE:
            begin
                item.kind = smm_pkg::KIND_COMPUTE;
                keep      = ({1'b0, request.row} < n_dim);
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign request.ready = (cnt_reg != 2'(QUEUE_DEPTH));
    assign push          = request.valid && request.ready && keep;
    assign pop           = q_pop && q_valid;

    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = q_mem_reg[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= item;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

### rtl/smm_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_engine
// Holds both matrices and computes one product row with a lane per column.
// ----------------------------------------------------------------------------
module smm_engine #(
    parameter int DIM = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  smm_pkg::smm_item_t            q_item,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  logic [smm_pkg::SIZE_W-1:0]    n_dim,
    smm_res_if.source                     result
);

    localparam int IW = $clog2(DIM);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // A store; each B column lives in its own lane
    logic signed [smm_pkg::VAL_W-1:0]  a_mem [DIM][DIM];

    state_t                             state_reg;
    logic [IW-1:0]                      r_reg;
    logic [IW-1:0]                      k_reg;
    logic [IW-1:0]                      col_reg;
    logic                               rd_vld_reg;
    logic                               mul_vld_reg;

    logic signed [smm_pkg::VAL_W-1:0]   a_rd_reg;
    logic signed [smm_pkg::ACC_W-1:0]   acc_col [DIM];

    logic                               out_vld_reg;
    logic signed [smm_pkg::ACC_W-1:0]   out_product_reg;
    logic [smm_pkg::IDX_W-1:0]          out_row_reg;
    logic [smm_pkg::IDX_W-1:0]          out_col_reg;
    logic                               out_last_reg;

    logic [smm_pkg::SIZE_W-1:0]         n_last;
    logic                               start;
    logic                               wr_a;
    logic                               wr_b;
    logic                               emit_go;

    assign n_last  = n_dim - 5'd1;
    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign start   = q_pop && (q_item.kind == smm_pkg::KIND_COMPUTE);
    assign wr_a    = q_pop && (q_item.kind == smm_pkg::KIND_LOAD_A);
    assign wr_b    = q_pop && (q_item.kind == smm_pkg::KIND_LOAD_B);
    assign emit_go = (state_reg == ST_EMIT) && (!out_vld_reg || result.ready);

    // A element writes and operand read
    always_ff @(posedge clk)
    begin
        if (wr_a)
        begin
            a_mem[q_item.row[IW-1:0]][q_item.col[IW-1:0]] <= q_item.value;
        end
        if (state_reg == ST_MAC)
        begin
            a_rd_reg <= a_mem[r_reg][k_reg];
        end
    end

    // column lanes: B column store, multiply, then accumulate
    for (genvar c = 0; c < DIM; c++)
    begin : g_lane
        logic signed [smm_pkg::VAL_W-1:0]   b_col_mem [DIM];
        logic signed [smm_pkg::VAL_W-1:0]   b_rd_reg;
        logic signed [smm_pkg::PROD_W-1:0]  prod_reg;
        logic signed [smm_pkg::ACC_W-1:0]   acc_reg;

        always_ff @(posedge clk)
        begin
            if (wr_b && (q_item.col[IW-1:0] == IW'(c)))
            begin
                b_col_mem[q_item.row[IW-1:0]] <= q_item.value;
            end
            if (state_reg == ST_MAC)
            begin
                b_rd_reg <= b_col_mem[k_reg];
            end
            prod_reg <= a_rd_reg * b_rd_reg;
            if (start)
            begin
                acc_reg <= '0;
            end
            else if (mul_vld_reg)
            begin
                acc_reg <= acc_reg + smm_pkg::ACC_W'(prod_reg);
            end
        end

        assign acc_col[c] = acc_reg;
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            r_reg           <= '0;
            k_reg           <= '0;
            col_reg         <= '0;
            rd_vld_reg      <= 1'b0;
            mul_vld_reg     <= 1'b0;
            out_vld_reg     <= 1'b0;
            out_product_reg <= '0;
            out_row_reg     <= '0;
            out_col_reg     <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= (state_reg == ST_MAC);
            mul_vld_reg <= rd_vld_reg;
            if (emit_go)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        r_reg     <= q_item.row[IW-1:0];
                        k_reg     <= '0;
                        state_reg <= ST_MAC;
                    end
                end
                ST_MAC:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (smm_pkg::SIZE_W'(k_reg) == n_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!rd_vld_reg && !mul_vld_reg)
                    begin
                        col_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_product_reg <= acc_col[col_reg];
                        out_row_reg     <= smm_pkg::IDX_W'(r_reg);
                        out_col_reg     <= smm_pkg::IDX_W'(col_reg);
                        out_last_reg    <= (smm_pkg::SIZE_W'(col_reg) == n_last);
                        col_reg         <= col_reg + 1'b1;
                        if (smm_pkg::SIZE_W'(col_reg) == n_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result.valid   = out_vld_reg;
    assign result.product = out_product_reg;
    assign result.out_row = out_row_reg;
    assign result.out_col = out_col_reg;
    assign result.last    = out_last_reg;

    // emitting starts only once the lane pipeline is empty
    a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> !rd_vld_reg && !mul_vld_reg)
        else $error("emit with lane pipeline busy");

    // last flag marks exactly the final active column
    a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (out_last_reg == ({1'b0, out_col_reg} == n_last)))
        else $error("last flag on wrong column");

    // emitted row lies inside the active dimension
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> ({1'b0, out_row_reg} < n_dim))
        else $error("result row outside active dimension");

    // reduction index never runs past the active dimension
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MAC |-> smm_pkg::SIZE_W'(k_reg) <= n_last)
        else $error("reduction index out of range");

endmodule

### rtl/square_matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_matrix_multiply
// Square matrix multiplier, A times B, with signed 16-bit elements.
// ----------------------------------------------------------------------------
// Load words write one element of A or B in the back end. A compute word for
// row r reads one A element per cycle, and each of a bank of column lanes
// (one multiplier each) reads its own B element, so with n the active
// dimension the row is reduced over n terms, the lane pipeline (operand
// read, multiply, accumulate) drains, and the row is emitted at one result
// word per cycle from the output register while the sink keeps up. A
// two-word queue separates the request side from the back end; words with
// no effect (unused command, load outside the store, row outside the active
// dimension) are dropped at the front. Matrices are not cleared.
// ----------------------------------------------------------------------------
module square_matrix_multiply #(
    parameter int MAX_DIM = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    smm_req_if.sink                       request,
    smm_res_if.source                     result,
    input  logic                          cfg_wr_en,
    input  logic [smm_pkg::SIZE_W-1:0]    cfg_wr_data
);

    // only rows and columns below the row limit can ever be read
    localparam int DIM = (MAX_DIM < smm_pkg::ROW_LIMIT) ? MAX_DIM : smm_pkg::ROW_LIMIT;

    logic [smm_pkg::SIZE_W-1:0] size_reg;
    logic [smm_pkg::SIZE_W-1:0] n_dim;

    smm_pkg::smm_item_t         q_item;
    logic                       q_valid;
    logic                       q_pop;

    // size_in_use register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= smm_pkg::SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            size_reg <= cfg_wr_data;
        end
    end

    assign n_dim = smm_pkg::active_dim(size_reg, smm_pkg::SIZE_W'(DIM));

    smm_front #(
        .DIM (DIM)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .n_dim   (n_dim),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    smm_engine #(
        .DIM (DIM)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .n_dim   (n_dim),
        .result  (result)
    );

endmodule

### bench/tb_square_matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_square_matrix_multiply
// Self-checking bench for the square matrix multiplier.
// ----------------------------------------------------------------------------
// A queue of request words is built phase by phase: a short directed set at a
// small dimension, then random phases over a spread of size settings, small
// ones mostly, saturated and full size too. Each random phase is mostly
// element refreshes followed by row computes, with noise loads, unused
// commands and rows outside the active dimension mixed in. The bench never
// reads an element that was not loaded first. A clocked driver sends the
// words in bursts with random gaps, and the result side stalls on its own
// pattern. Every accepted request word updates a local copy of both matrices
// and, for live row computes, queues the expected row; every result word is checked
// field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_square_matrix_multiply;

    localparam int MATRIX_DIM    = 16;
    localparam int SETTLE_CYCLES = 60;
    localparam int PHASE_ITEMS   = 4;
    localparam int NUM_PHASES    = 10;
    localparam int MAX_REPORTS   = 10;

    // command code the block leaves unused
    localparam logic [smm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam logic signed [smm_pkg::VAL_W-1:0] ELEM_MIN = 16'sh8000;
    localparam logic signed [smm_pkg::VAL_W-1:0] ELEM_MAX = 16'sh7FFF;

    typedef struct {
        logic [smm_pkg::CMD_W-1:0]         command;
        logic [smm_pkg::IDX_W-1:0]         row;
        logic [smm_pkg::IDX_W-1:0]         col;
        logic signed [smm_pkg::VAL_W-1:0]  value;
        bit                                hold;     // pause marker: wait for all results
    } req_word_t;

    typedef struct packed {
        logic signed [smm_pkg::ACC_W-1:0]  product;
        logic [smm_pkg::IDX_W-1:0]         out_row;
        logic [smm_pkg::IDX_W-1:0]         out_col;
        logic                              last;
    } product_word_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [smm_pkg::SIZE_W-1:0]     cfg_wr_data;

    smm_req_if req_ch();
    smm_res_if res_ch();

    square_matrix_multiply #(
        .MAX_DIM     (MATRIX_DIM)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .request     (req_ch),
        .result      (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // words waiting to be sent, and product words still owed by the block
    req_word_t      pending_words[$];
    product_word_t  expected_products[$];

    // local copy of the block state
    logic signed [smm_pkg::VAL_W-1:0] a_elems [MATRIX_DIM*MATRIX_DIM];
    logic signed [smm_pkg::VAL_W-1:0] b_elems [MATRIX_DIM*MATRIX_DIM];
    logic [smm_pkg::SIZE_W-1:0]       size_model;

    // stimulus side bookkeeping: which elements have been loaded so far
    bit  a_loaded [MATRIX_DIM*MATRIX_DIM];
    bit  b_loaded [MATRIX_DIM*MATRIX_DIM];
    int  plan_dim;
    int  counted_items;

    // driver and receiver pacing
    req_word_t  drive_word;
    logic       word_taken;
    int         burst_left;
    int         gap_left;
    int         run_left;
    int         stall_left;

    // run statistics
    int  words_taken  = 0;
    int  rows_taken   = 0;
    int  results_seen = 0;
    int  mismatches   = 0;
    int  holds_done   = 0;
    int  settings_used;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------------

    // effective dimension for a size setting
    function automatic int dim_of(input logic [smm_pkg::SIZE_W-1:0] size);
        int n;
        n = int'(size);
        if (n == 0)
        begin
            n = 1;
        end
        if (n > MATRIX_DIM)
        begin
            n = MATRIX_DIM;
        end
        if (n > smm_pkg::ROW_LIMIT)
        begin
            n = smm_pkg::ROW_LIMIT;
        end
        return n;
    endfunction

    // element value, biased toward the corners of the range
    function automatic logic signed [smm_pkg::VAL_W-1:0] rand_elem();
        logic signed [smm_pkg::VAL_W-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = ELEM_MIN;
            1:       v = ELEM_MAX;
            2:       v = '0;
            3:       v = '1;
            default: v = smm_pkg::VAL_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic queue_word(input logic [smm_pkg::CMD_W-1:0] cmd, input int r, input int c,
                              input logic signed [smm_pkg::VAL_W-1:0] v, input bit hold);
        req_word_t w;
        w.command = cmd;
        w.row     = smm_pkg::IDX_W'(r);
        w.col     = smm_pkg::IDX_W'(c);
        w.value   = v;
        w.hold    = hold;
        pending_words.push_back(w);
    endtask

    task automatic queue_load(input logic [smm_pkg::CMD_W-1:0] cmd, input int r, input int c,
                              input logic signed [smm_pkg::VAL_W-1:0] v);
        queue_word(cmd, r, c, v, 1'b0);
        if (cmd == smm_pkg::CMD_LOAD_A)
        begin
            a_loaded[r*MATRIX_DIM + c] = 1'b1;
        end
        else
        begin
            b_loaded[r*MATRIX_DIM + c] = 1'b1;
        end
        counted_items++;
    endtask

    // compute of row r; loads any element the row would read that is still unset
    task automatic queue_row_compute(input int r);
        if (r < plan_dim)
        begin
            for (int k = 0; k < plan_dim; k++)
            begin
                if (!a_loaded[r*MATRIX_DIM + k])
                begin
                    queue_load(smm_pkg::CMD_LOAD_A, r, k, rand_elem());
                end
            end
            for (int k = 0; k < plan_dim; k++)
            begin
                for (int c = 0; c < plan_dim; c++)
                begin
                    if (!b_loaded[k*MATRIX_DIM + c])
                    begin
                        queue_load(smm_pkg::CMD_LOAD_B, k, c, rand_elem());
                    end
                end
            end
            counted_items++;
        end
        // col and value are don't-care on a compute
        queue_word(smm_pkg::CMD_COMPUTE, r, $urandom_range(0, 15),
                   smm_pkg::VAL_W'($urandom), 1'b0);
    endtask

    // A row r and B column c set to constants, then row r computed
    task automatic queue_extreme_row(input int r, input int c,
                                     input logic signed [smm_pkg::VAL_W-1:0] va,
                                     input logic signed [smm_pkg::VAL_W-1:0] vb);
        for (int k = 0; k < plan_dim; k++)
        begin
            queue_load(smm_pkg::CMD_LOAD_A, r, k, va);
            queue_load(smm_pkg::CMD_LOAD_B, k, c, vb);
        end
        queue_row_compute(r);
    endtask

    // one random phase at the current dimension
    task automatic queue_random_phase();
        int  phase_start;
        int  pick;
        bit  held;
        phase_start = counted_items;
        held        = 1'b0;
        while (counted_items < phase_start + PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // refresh a few active elements, then compute a live row
                repeat ($urandom_range(0, 3))
                begin
                    queue_load($urandom_range(0, 1) ? smm_pkg::CMD_LOAD_B : smm_pkg::CMD_LOAD_A,
                               $urandom_range(0, plan_dim - 1),
                               $urandom_range(0, plan_dim - 1), rand_elem());
                end
                queue_row_compute($urandom_range(0, plan_dim - 1));
            end
            else if (pick < 72)
            begin
                queue_load($urandom_range(0, 1) ? smm_pkg::CMD_LOAD_B : smm_pkg::CMD_LOAD_A,
                           $urandom_range(0, 15), $urandom_range(0, 15), rand_elem());
            end
            else if (pick < 82)
            begin
                queue_word(CMD_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
                           smm_pkg::VAL_W'($urandom), 1'b0);
            end
            else if (pick < 95)
            begin
                // any row, live or outside the active dimension
                queue_row_compute($urandom_range(0, 15));
            end
            else
            begin
                queue_word(CMD_UNUSED, 0, 0, '0, 1'b1);
            end
            if (!held && counted_items >= phase_start + PHASE_ITEMS / 2)
            begin
                queue_word(CMD_UNUSED, 0, 0, '0, 1'b1);
                held = 1'b1;
            end
        end
    endtask

    // size register write, only while the block is idle
    task automatic write_size(input logic [smm_pkg::SIZE_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        plan_dim = dim_of(v);
        settings_used++;
    endtask

    // wait until everything sent has been answered, then let the block go quiet
    task automatic settle();
        while (pending_words.size() != 0 || req_ch.valid || expected_products.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // update the local state with one accepted word; computes queue a product row
    task automatic predict_product_row(input logic [smm_pkg::CMD_W-1:0] cmd,
                                       input logic [smm_pkg::IDX_W-1:0] r,
                                       input logic [smm_pkg::IDX_W-1:0] c,
                                       input logic signed [smm_pkg::VAL_W-1:0] v);
        int             n;
        longint         acc;
        product_word_t  p;
        case (cmd)
            smm_pkg::CMD_LOAD_A:
            begin
                a_elems[r*MATRIX_DIM + c] = v;
            end
            smm_pkg::CMD_LOAD_B:
            begin
                b_elems[r*MATRIX_DIM + c] = v;
            end
            smm_pkg::CMD_COMPUTE:
            begin
                n = dim_of(size_model);
                if (r < n)
                begin
                    rows_taken++;
                    for (int col = 0; col < n; col++)
                    begin
                        acc = 0;
                        for (int k = 0; k < n; k++)
                        begin
                            acc += longint'(a_elems[r*MATRIX_DIM + k]) *
                                   longint'(b_elems[k*MATRIX_DIM + col]);
                        end
                        p.product = acc[smm_pkg::ACC_W-1:0];
                        p.out_row = r;
                        p.out_col = smm_pkg::IDX_W'(col);
                        p.last    = (col == n - 1);
                        expected_products.push_back(p);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // compare one result word with the oldest expected one
    task automatic check_product_word();
        product_word_t want;
        product_word_t got;
        got.product = res_ch.product;
        got.out_row = res_ch.out_row;
        got.out_col = res_ch.out_col;
        got.last    = res_ch.last;
        results_seen++;
        if (expected_products.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $display("ERROR %0t: unexpected result word row %0d col %0d product %0d last %0b",
                         $realtime, got.out_row, got.out_col, got.product, got.last);
            end
        end
        else
        begin
            want = expected_products.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("ERROR %0t: result word differs", $realtime);
                    $display("  expected row %0d col %0d product %0d last %0b",
                             want.out_row, want.out_col, want.product, want.last);
                    $display("  actual   row %0d col %0d product %0d last %0b",
                             got.out_row, got.out_col, got.product, got.last);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // request driver: bursts with gaps, fed from pending_words
    // ------------------------------------------------------------------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.command <= '0;
            req_ch.row     <= '0;
            req_ch.col     <= '0;
            req_ch.value   <= '0;
            burst_left     <= 0;
            gap_left       <= 0;
        end
        else if (req_ch.valid && !word_taken)
        begin
            // word still waiting for ready
        end
        else if (gap_left != 0)
        begin
            req_ch.valid <= 1'b0;
            gap_left     <= gap_left - 1;
        end
        else if (pending_words.size() == 0)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (pending_words[0].hold)
        begin
            // hold off until every owed result has come back
            req_ch.valid <= 1'b0;
            if (expected_products.size() == 0)
            begin
                void'(pending_words.pop_front());
                holds_done++;
            end
        end
        else
        begin
            drive_word = pending_words.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.command <= drive_word.command;
            req_ch.row     <= drive_word.row;
            req_ch.col     <= drive_word.col;
            req_ch.value   <= drive_word.value;
            if (burst_left <= 1)
            begin
                burst_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                                          : $urandom_range(1, 8);
                gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
            else
            begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result ready: long open runs and short or long stalls
    // ------------------------------------------------------------------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            run_left     <= 0;
            stall_left   <= 0;
        end
        else if (run_left != 0)
        begin
            res_ch.ready <= 1'b1;
            run_left     <= run_left - 1;
        end
        else if (stall_left != 0)
        begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            run_left     <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 6);
            stall_left   <= ($urandom_range(0, 4) == 0) ? $urandom_range(8, 16)
                                                        : $urandom_range(1, 3);
        end
    end

    // ------------------------------------------------------------------------
    // monitor: handshakes at the rising edge feed the prediction and the check
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_taken <= 1'b0;
            size_model = smm_pkg::SIZE_RESET;
        end
        else
        begin
            word_taken <= req_ch.valid && req_ch.ready;
            if (cfg_wr_en)
            begin
                size_model = cfg_wr_data;
            end
            if (res_ch.valid && res_ch.ready)
            begin
                check_product_word();
            end
            if (req_ch.valid && req_ch.ready)
            begin
                words_taken++;
                predict_product_row(req_ch.command, req_ch.row, req_ch.col, req_ch.value);
            end
        end
    end

    // ------------------------------------------------------------------------
    // run limit
    // ------------------------------------------------------------------------
    initial
    begin
        #2ms;
        $display("timeout: %0d result words still owed", expected_products.size());
        $display("square_matrix_multiply: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [smm_pkg::SIZE_W-1:0] phase_sizes [NUM_PHASES];
        bit                         wide_done;

        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        counted_items  = 0;
        settings_used  = 0;
        wide_done      = 1'b0;
        plan_dim       = dim_of(smm_pkg::SIZE_RESET);
        foreach (a_loaded[i])
        begin
            a_loaded[i] = 1'b0;
            b_loaded[i] = 1'b0;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: corner values at dimension 2, ignored words, dead rows
        write_size(5'd2);
        queue_extreme_row(0, 0, ELEM_MIN, ELEM_MIN);
        queue_extreme_row(1, 1, ELEM_MAX, ELEM_MIN);
        queue_load(smm_pkg::CMD_LOAD_A, 15, 15, 16'sh5555);
        queue_load(smm_pkg::CMD_LOAD_B, 15, 0, 16'shAAAA);
        queue_word(CMD_UNUSED, 15, 15, '1, 1'b0);
        queue_row_compute(2);
        queue_row_compute(15);
        queue_load(smm_pkg::CMD_LOAD_A, 0, 1, '0);
        queue_row_compute(0);
        queue_load(smm_pkg::CMD_LOAD_B, 1, 0, 16'sd1);
        queue_load(smm_pkg::CMD_LOAD_A, 0, 0, 16'sd1);
        queue_row_compute(1);
        settle();

        // random phases over zero, small, mid, saturated and full sizes
        phase_sizes = '{5'd0, 5'd3, 5'd31, 5'd1, 5'd5, 5'd16, 5'd4,
                        5'($urandom_range(6, 15)), 5'd2, 5'($urandom_range(17, 30))};
        foreach (phase_sizes[i])
        begin
            write_size(phase_sizes[i]);
            if (plan_dim == MATRIX_DIM && !wide_done)
            begin
                // full width sums at both ends of the product range
                queue_extreme_row(0, 0, ELEM_MIN, ELEM_MIN);
                queue_extreme_row(1, 1, ELEM_MAX, ELEM_MIN);
                wide_done = 1'b1;
            end
            queue_random_phase();
            settle();
        end

        $display("covered %0d request words, %0d row computes, %0d result words checked",
                 words_taken, rows_taken, results_seen);
        $display("over %0d size settings with %0d drain pauses; %0d errors",
                 settings_used, holds_done, mismatches);
        if (mismatches == 0)
        begin
            $display("square_matrix_multiply: match");
        end
        else
        begin
            $display("square_matrix_multiply: mismatch");
        end
        $finish;
    end

endmodule
